/* rtl/trm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_pkg
// Shared widths, register indexes and the region record type.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int SCORE_W   = 32;
  localparam int POS_W     = 31;
  localparam int SEQ_W     = 16;
  localparam int IDX_W     = 20;
  localparam int NUM_W     = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [IDX_W-1:0] IDX_LAST  = {IDX_W{1'b1}};
  localparam logic [NUM_W-1:0] TOTAL_MAX = {NUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BELOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE  = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // pend bit order: close, flush, summary
  localparam int P_CLOSE   = 0;
  localparam int P_FLUSH   = 1;
  localparam int P_SUMMARY = 2;

  typedef struct packed {
    logic [2:0]       pend;
    logic [NUM_W-1:0] c_num;
    logic [IDX_W-1:0] c_start;
    logic [IDX_W-1:0] c_end;
    logic [NUM_W-1:0] f_num;
    logic [IDX_W-1:0] f_start;
    logic [IDX_W-1:0] f_end;
    logic [NUM_W-1:0] s_num;
  } rec_t;

endpackage
`default_nettype wire

/* rtl/threshold_region_merger.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_region_merger
// Threshold region caller with gap merge over a sorted probe stream.
// ----------------------------------------------------------------------------
// One probe is taken per cycle while in_full is low. The hit compare runs on
// the probe as it is taken, and the region tracker updates all region state
// from the stage register once the queue has room; region records then pass
// a four-entry queue to the result stage, which loads a record and gives one
// result per cycle from its output register while that register is empty or
// popped. A probe that yields several results (close, flush, summary) holds
// the result side until each has been given, and the input stalls only once
// the queue is full.
// ----------------------------------------------------------------------------
module threshold_region_merger
  import trm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [SCORE_W-1:0]   in_score,
  input  wire logic [POS_W-1:0]     in_position,
  input  wire logic [SEQ_W-1:0]     in_seq_id,
  input  wire logic                 in_last_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic                      out_result_kind,
  output logic [NUM_W-1:0]          out_region_number,
  output logic [IDX_W-1:0]          out_start_index,
  output logic [IDX_W-1:0]          out_end_index,
  output logic                      out_final_result
);

  rec_t q_wr_rec;
  rec_t q_head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_nonempty;

  trm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_score     (in_score),
    .in_position  (in_position),
    .in_seq_id    (in_seq_id),
    .in_last_item (in_last_item),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (q_wr_rec)
  );

  trm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_rec   (q_wr_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty)
  );

  trm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_nonempty        (q_nonempty),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_kind   (out_result_kind),
    .out_region_number (out_region_number),
    .out_start_index   (out_start_index),
    .out_end_index     (out_end_index),
    .out_final_result  (out_final_result)
  );

endmodule
`default_nettype wire

/* rtl/trm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_front
// Hold configuration, classify probes as hits and track the open region.
// ----------------------------------------------------------------------------
module trm_front
  import trm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [SCORE_W-1:0]   in_score,
  input  wire logic [POS_W-1:0]     in_position,
  input  wire logic [SEQ_W-1:0]     in_seq_id,
  input  wire logic                 in_last_item,
  input  wire logic                 q_full,
  output logic                      q_push,
  output rec_t                      q_rec
);

  logic [SCORE_W-1:0] offset_r;
  logic [SCORE_W-1:0] cutoff_r;
  logic               below_r;
  logic [POS_W-1:0]   merge_r;

  logic               a_vld_r;
  logic               a_hit_r;
  logic [POS_W-1:0]   a_pos_r;
  logic [SEQ_W-1:0]   a_seq_r;
  logic               a_last_r;

  logic               open_r,   open_nxt;
  logic [IDX_W-1:0]   start_r,  start_nxt;
  logic [IDX_W-1:0]   lhi_r,    lhi_nxt;
  logic [POS_W-1:0]   lhp_r,    lhp_nxt;
  logic [SEQ_W-1:0]   lhs_r,    lhs_nxt;
  logic [NUM_W-1:0]   total_r,  total_nxt;
  logic [IDX_W-1:0]   cnt_r,    cnt_nxt;

  logic signed [SCORE_W:0] diff;
  logic signed [SCORE_W:0] cut;
  logic                    hit;
  logic signed [POS_W:0]   gap;
  logic                    b_go;
  logic                    a_take;
  logic                    taken;
  logic                    do_close;

  assign diff = $signed({in_score[SCORE_W-1], in_score})
              - $signed({offset_r[SCORE_W-1], offset_r});
  assign cut  = $signed({cutoff_r[SCORE_W-1], cutoff_r});
  assign hit  = below_r ? (diff < cut) : (diff > cut);

  assign b_go    = a_vld_r && !q_full;
  assign in_full = a_vld_r && q_full;
  assign a_take  = !in_full;
  assign gap     = $signed({1'b0, a_pos_r}) - $signed({1'b0, lhp_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      cutoff_r <= '0;
      below_r  <= 1'b0;
      merge_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OFFSET: offset_r <= cfg_wdata;
        REG_CUTOFF: cutoff_r <= cfg_wdata;
        REG_BELOW:  below_r  <= cfg_wdata[0];
        REG_MERGE:  merge_r  <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_take) begin
      a_vld_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_hit_r  <= hit;
      a_pos_r  <= in_position;
      a_seq_r  <= in_seq_id;
      a_last_r <= in_last_item;
    end
  end

  always_comb begin
    open_nxt  = open_r;
    start_nxt = start_r;
    lhi_nxt   = lhi_r;
    lhp_nxt   = lhp_r;
    lhs_nxt   = lhs_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    taken     = 1'b0;
    do_close  = 1'b0;
    q_rec     = '0;

    if (open_r) begin
      if ((a_seq_r == lhs_r) && (gap <= $signed({1'b0, merge_r}))) begin
        taken = 1'b1;
        if (a_hit_r) begin
          lhi_nxt = cnt_r;
          lhp_nxt = a_pos_r;
        end
      end else begin
        do_close = 1'b1;
        open_nxt = 1'b0;
      end
    end

    if (!taken && a_hit_r) begin
      open_nxt  = 1'b1;
      if (total_r != TOTAL_MAX) begin
        total_nxt = total_r + 1'b1;
      end
      start_nxt = cnt_r;
      lhi_nxt   = cnt_r;
      lhp_nxt   = a_pos_r;
      lhs_nxt   = a_seq_r;
    end

    q_rec.pend[P_CLOSE] = do_close;
    q_rec.c_num         = total_r;
    q_rec.c_start       = start_r;
    q_rec.c_end         = lhi_r;
    q_rec.f_num         = total_nxt;
    q_rec.f_start       = start_nxt;
    q_rec.f_end         = lhi_nxt;
    q_rec.s_num         = total_nxt;

    if (a_last_r) begin
      q_rec.pend[P_FLUSH]   = open_nxt;
      q_rec.pend[P_SUMMARY] = 1'b1;
      open_nxt  = 1'b0;
      total_nxt = '0;
      cnt_nxt   = '0;
    end else begin
      cnt_nxt = (cnt_r == IDX_LAST) ? '0 : cnt_r + 1'b1;
    end
  end

  assign q_push = b_go && (|q_rec.pend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      lhi_r   <= '0;
      lhp_r   <= '0;
      lhs_r   <= '0;
      total_r <= '0;
      cnt_r   <= '0;
    end else if (b_go) begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      lhi_r   <= lhi_nxt;
      lhp_r   <= lhp_nxt;
      lhs_r   <= lhs_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/trm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_queue
// Short record queue between the region tracker and the result stage.
// ----------------------------------------------------------------------------
module trm_queue
  import trm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t wr_rec,
  output logic      full,
  input  wire logic pop,
  output rec_t      head,
  output logic      nonempty
);

  rec_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r,    cnt_nxt;

  assign full     = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule
`default_nettype wire

/* rtl/trm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_back
// Expand each region record into result transfers, one per cycle while the output is empty or popped.
// ----------------------------------------------------------------------------
module trm_back
  import trm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rec_t              q_head,
  input  wire logic              q_nonempty,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_result_kind,
  output logic [NUM_W-1:0]       out_region_number,
  output logic [IDX_W-1:0]       out_start_index,
  output logic [IDX_W-1:0]       out_end_index,
  output logic                   out_final_result
);

  rec_t             cur_r;
  logic [2:0]       pend_r,  pend_nxt;
  logic             out_vld_r;
  logic             kind_r,  kind_nxt;
  logic [NUM_W-1:0] num_r,   num_nxt;
  logic [IDX_W-1:0] sidx_r,  sidx_nxt;
  logic [IDX_W-1:0] eidx_r,  eidx_nxt;
  logic             fin_r,   fin_nxt;
  logic             slot;
  logic             emit;
  logic [2:0]       pend_after;

  assign slot = !out_vld_r || out_pop;
  assign emit = slot && (|pend_r);

  always_comb begin
    pend_after = pend_r;
    kind_nxt   = 1'b1;
    num_nxt    = cur_r.s_num;
    sidx_nxt   = '0;
    eidx_nxt   = '0;
    if (pend_r[P_CLOSE]) begin
      pend_after[P_CLOSE] = 1'b0;
      kind_nxt = 1'b0;
      num_nxt  = cur_r.c_num;
      sidx_nxt = cur_r.c_start;
      eidx_nxt = cur_r.c_end;
    end else if (pend_r[P_FLUSH]) begin
      pend_after[P_FLUSH] = 1'b0;
      kind_nxt = 1'b0;
      num_nxt  = cur_r.f_num;
      sidx_nxt = cur_r.f_start;
      eidx_nxt = cur_r.f_end;
    end else begin
      pend_after[P_SUMMARY] = 1'b0;
    end
    if (!emit) begin
      pend_after = pend_r;
    end
    fin_nxt  = (pend_after == 3'b000);
    q_pop    = (pend_after == 3'b000) && q_nonempty;
    pend_nxt = q_pop ? q_head.pend : pend_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (slot) begin
        out_vld_r <= |pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (emit) begin
      kind_r <= kind_nxt;
      num_r  <= num_nxt;
      sidx_r <= sidx_nxt;
      eidx_r <= eidx_nxt;
      fin_r  <= fin_nxt;
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_result_kind   = kind_r;
  assign out_region_number = num_r;
  assign out_start_index   = sidx_r;
  assign out_end_index     = eidx_r;
  assign out_final_result  = fin_r;

endmodule
`default_nettype wire

/* tb/threshold_region_merger_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_region_merger_tb
// Self-checking bench for the threshold region caller with gap merge.
// Probes go in through the push/full queue port and region reports come out
// through the empty/pop port, both sides with random idle cycles. A model of
// the region tracker built into the bench predicts every report, and each
// popped transfer is compared field by field with the oldest prediction.
// Directed tests cover reset values, threshold extremes, gap merging and a
// gap-free stream with one region per probe; random probe streams with
// changing register settings follow.
// ----------------------------------------------------------------------------
module threshold_region_merger_tb;
  import trm_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PROBES = 380;
  localparam int BURST_PROBES  = 20;
  localparam int PRINT_CAP     = 50;

  localparam logic KIND_REGION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic MODE_ABOVE   = 1'b0;
  localparam logic MODE_BELOW   = 1'b1;

  localparam logic [SCORE_W-1:0] Q16_ONE  = 32'h0001_0000;
  localparam logic [SCORE_W-1:0] Q16_HALF = 32'h0000_8000;
  localparam logic [SCORE_W-1:0] Q16_TWO  = 32'h0002_0000;
  localparam logic [SCORE_W-1:0] S_MIN    = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] S_MAX    = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [NUM_W-1:0] number;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] last_idx;
    logic             final_flag;
  } region_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_push;
  logic                 in_full;
  logic [SCORE_W-1:0]   in_score;
  logic [POS_W-1:0]     in_position;
  logic [SEQ_W-1:0]     in_seq_id;
  logic                 in_last_item;
  logic                 out_empty;
  logic                 out_pop;
  logic                 out_result_kind;
  logic [NUM_W-1:0]     out_region_number;
  logic [IDX_W-1:0]     out_start_index;
  logic [IDX_W-1:0]     out_end_index;
  logic                 out_final_result;

  // register copies
  logic signed [SCORE_W-1:0] cur_offset;
  logic signed [SCORE_W-1:0] cur_cutoff;
  logic                      cur_below;
  logic [POS_W-1:0]          cur_merge;

  // region tracker copy
  logic             trk_open;
  logic [IDX_W-1:0] trk_first;
  logic [IDX_W-1:0] trk_last_hit;
  logic [POS_W-1:0] trk_last_pos;
  logic [SEQ_W-1:0] trk_seq;
  logic [NUM_W-1:0] trk_total;
  logic [IDX_W-1:0] trk_index;

  region_rec_t pending_regions[$];
  region_rec_t got_rec;
  region_rec_t want_rec;

  bit in_gaps_on;
  bit out_gaps_on;
  int mismatch_count  = 0;
  int results_checked = 0;
  int probes_sent     = 0;

  threshold_region_merger uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_score          (in_score),
    .in_position       (in_position),
    .in_seq_id         (in_seq_id),
    .in_last_item      (in_last_item),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_kind   (out_result_kind),
    .out_region_number (out_region_number),
    .out_start_index   (out_start_index),
    .out_end_index     (out_end_index),
    .out_final_result  (out_final_result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not complete in time", $time);
    $display("simulation failed");
    $finish;
  end

  task automatic track_regions(input logic [SCORE_W-1:0] score, input logic [POS_W-1:0] pos,
                               input logic [SEQ_W-1:0] seq, input logic last);
    region_rec_t recs[3];
    int          n;
    int          k;
    longint      diff;
    longint      gap;
    logic        hit;
    logic        kept;
    n    = 0;
    kept = 1'b0;
    diff = longint'($signed(score)) - longint'(cur_offset);
    hit  = (cur_below == MODE_BELOW) ? (diff < longint'(cur_cutoff))
                                     : (diff > longint'(cur_cutoff));
    if (trk_open) begin
      gap = longint'({1'b0, pos}) - longint'({1'b0, trk_last_pos});
      if (seq == trk_seq && gap <= longint'({1'b0, cur_merge})) begin
        kept = 1'b1;
        if (hit) begin
          trk_last_hit = trk_index;
          trk_last_pos = pos;
        end
      end else begin
        recs[n] = '{KIND_REGION, trk_total, trk_first, trk_last_hit, 1'b0};
        n++;
        trk_open = 1'b0;
      end
    end
    if (!kept && hit) begin
      trk_open = 1'b1;
      if (trk_total != TOTAL_MAX) trk_total++;
      trk_first    = trk_index;
      trk_last_hit = trk_index;
      trk_last_pos = pos;
      trk_seq      = seq;
    end
    if (last) begin
      if (trk_open) begin
        recs[n] = '{KIND_REGION, trk_total, trk_first, trk_last_hit, 1'b0};
        n++;
      end
      recs[n] = '{KIND_SUMMARY, trk_total, {IDX_W{1'b0}}, {IDX_W{1'b0}}, 1'b0};
      n++;
      trk_open  = 1'b0;
      trk_total = '0;
      trk_index = '0;
    end else begin
      trk_index++;
    end
    if (n > 0) recs[n-1].final_flag = 1'b1;
    for (k = 0; k < n; k++) pending_regions.push_back(recs[k]);
  endtask

  function automatic void check_field(input string label, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      got_rec = '{out_result_kind, out_region_number, out_start_index, out_end_index,
                  out_final_result};
      if (pending_regions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
          $display("%0t: unexpected transfer, expected none, got kind %0d number %0d",
                   $time, got_rec.kind, got_rec.number);
      end else begin
        want_rec = pending_regions.pop_front();
        results_checked++;
        check_field("result_kind", 32'(want_rec.kind), 32'(got_rec.kind));
        check_field("region_number", 32'(want_rec.number), 32'(got_rec.number));
        check_field("start_index", 32'(want_rec.first_idx), 32'(got_rec.first_idx));
        check_field("end_index", 32'(want_rec.last_idx), 32'(got_rec.last_idx));
        check_field("final_result", 32'(want_rec.final_flag), 32'(got_rec.final_flag));
      end
    end
  end

  initial begin
    int unsigned stall;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_gaps_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  task automatic send_probe(input logic [SCORE_W-1:0] score, input logic [POS_W-1:0] pos,
                            input logic [SEQ_W-1:0] seq, input logic last);
    int unsigned idle;
    idle = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (idle != 0) begin
      in_push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_score     <= score;
    in_position  <= pos;
    in_seq_id    <= seq;
    in_last_item <= last;
    do @(posedge clk); while (in_full);
    track_regions(score, pos, seq, last);
    probes_sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] offset_w, input logic [CFG_W-1:0] cutoff_w,
                             input logic [CFG_W-1:0] below_w, input logic [CFG_W-1:0] merge_w);
    write_reg(REG_OFFSET, offset_w);
    write_reg(REG_CUTOFF, cutoff_w);
    write_reg(REG_BELOW, below_w);
    write_reg(REG_MERGE, merge_w);
    cfg_wr_en  <= 1'b0;
    cur_offset = offset_w;
    cur_cutoff = cutoff_w;
    cur_below  = below_w[0];
    cur_merge  = merge_w[POS_W-1:0];
  endtask

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return S_MIN;
      2:       return S_MAX;
      3:       return $urandom();
      default: return CFG_W'(int'($urandom_range(0, 8 * Q16_ONE)) - 4 * int'(Q16_ONE));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    logic [SCORE_W-1:0] edge_val;
    edge_val = cur_offset + cur_cutoff;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return edge_val;
      2:       return edge_val + SCORE_W'(int'($urandom_range(0, 8)) - 4);
      default: return edge_val + SCORE_W'(int'($urandom_range(0, 2 * Q16_ONE)) - int'(Q16_ONE));
    endcase
  endfunction

  task automatic test_reset_values();
    // registers untouched: offset, cutoff and merge distance all zero
    send_probe(32'd1, 31'd5, 16'd0, 1'b0);
    send_probe(32'd0, 31'd5, 16'd0, 1'b0);
    send_probe(32'hFFFF_FFFF, 31'd6, 16'd0, 1'b0);
    send_probe(32'd2, 31'd7, 16'd0, 1'b1);
    drain();
  endtask

  task automatic test_threshold_extremes();
    // difference beyond 32 bits, equality at the cutoff is no hit
    load_config(S_MIN, S_MAX, {31'd0, MODE_ABOVE}, {1'b1, POS_MAX});
    send_probe(S_MAX, 31'd0, 16'hFFFF, 1'b0);
    send_probe(32'd0, POS_MAX, 16'hFFFF, 1'b0);
    send_probe(32'hFFFF_FFFF, 31'd0, 16'hFFFF, 1'b1);
    drain();
    load_config(S_MAX, S_MIN, {31'h7FFF_FFFF, MODE_BELOW}, '0);
    send_probe(S_MIN, POS_MAX, 16'd0, 1'b0);
    send_probe(32'd0, POS_MAX, 16'd0, 1'b0);
    send_probe(32'hFFFF_FFFF, POS_MAX, 16'd0, 1'b1);
    drain();
  endtask

  task automatic test_gap_merge();
    load_config(Q16_ONE, Q16_HALF, {31'd0, MODE_ABOVE}, 32'd10);
    send_probe(Q16_TWO, 31'd100, 16'd3, 1'b0);
    send_probe(32'd0, 31'd105, 16'd3, 1'b0);
    send_probe(Q16_TWO, 31'd110, 16'd3, 1'b0);
    // position going backwards stays inside the region
    send_probe(Q16_TWO, 31'd104, 16'd3, 1'b0);
    send_probe(32'd0, 31'd115, 16'd3, 1'b0);
    send_probe(Q16_TWO, 31'd115, 16'd3, 1'b0);
    send_probe(Q16_TWO, 31'd116, 16'd4, 1'b0);
    // close, flush and summary from one probe
    send_probe(Q16_TWO, 31'd200, 16'd4, 1'b1);
    send_probe(32'd0, 31'd0, 16'd0, 1'b1);
    drain();
  endtask

  task automatic test_back_to_back();
    int i;
    // every probe a hit one step past the last: one region per probe
    load_config('0, '0, {31'd0, MODE_ABOVE}, '0);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    for (i = 0; i < BURST_PROBES; i++)
      send_probe(32'd1, POS_W'(i), 16'd9, i == BURST_PROBES - 1);
    drain();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int               sent;
    int               len;
    int               j;
    int unsigned      back;
    logic [POS_W-1:0] pos;
    logic [SEQ_W-1:0] seq;
    logic [CFG_W-1:0] merge_w;
    sent = 0;
    while (sent < RANDOM_PROBES) begin
      if ($urandom_range(0, 1) == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0:       merge_w = '0;
          1:       merge_w = {1'b0, POS_MAX};
          2:       merge_w = $urandom();
          default: merge_w = $urandom_range(1, 50);
        endcase
        merge_w[CFG_W-1] = $urandom_range(0, 1);
        load_config(pick_threshold(), pick_threshold(),
                    {31'($urandom()), 1'($urandom_range(0, 1))}, merge_w);
      end
      in_gaps_on  = $urandom_range(0, 3) != 0;
      out_gaps_on = $urandom_range(0, 3) != 0;
      len = $urandom_range(1, 40);
      seq = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
      pos = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1000));
      for (j = 0; j < len; j++) begin
        send_probe(pick_score(), pos, seq, j == len - 1);
        case ($urandom_range(0, 11))
          0: begin
            seq++;
            pos = POS_W'($urandom_range(0, 1000));
          end
          1: begin
            back = $urandom_range(0, 50);
            pos  = (pos > back) ? pos - POS_W'(back) : '0;
          end
          2: begin
            seq = SEQ_W'($urandom());
            pos = POS_W'($urandom());
          end
          default: begin
            if (cur_merge <= 1000)
              pos = pos + POS_W'($urandom_range(0, 2 * cur_merge + 2));
            else
              pos = pos + ($urandom_range(0, 1) ? POS_W'($urandom_range(0, 1000))
                                                : cur_merge + POS_W'($urandom_range(0, 1)));
          end
        endcase
      end
      sent += len;
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_OFFSET;
    cfg_wdata    = '0;
    in_push      = 1'b0;
    in_score     = '0;
    in_position  = '0;
    in_seq_id    = '0;
    in_last_item = 1'b0;
    in_gaps_on   = 1'b1;
    out_gaps_on  = 1'b1;
    cur_offset   = '0;
    cur_cutoff   = '0;
    cur_below    = MODE_ABOVE;
    cur_merge    = '0;
    trk_open     = 1'b0;
    trk_first    = '0;
    trk_last_hit = '0;
    trk_last_pos = '0;
    trk_seq      = '0;
    trk_total    = '0;
    trk_index    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_threshold_extremes();
    test_gap_merge();
    test_back_to_back();
    test_random_streams();

    $display("Sent %0d probes and checked %0d region transfers, %0d mismatches.",
             probes_sent, results_checked, mismatch_count);
    $display("Covered cutoff extremes, both modes, gap merge, gap-free bursts, random setups.");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* threshold_region_merger.f */
rtl/trm_pkg.sv
rtl/trm_front.sv
rtl/trm_queue.sv
rtl/trm_back.sv
rtl/threshold_region_merger.sv
tb/threshold_region_merger_tb.sv
